/* hw/rtl/bps_pkg.sv */
`timescale 1ns / 1ps

package bps_pkg;

  localparam int DATA_BITS       = 8;
  localparam int PATTERN_REG_BITS = 64;
  localparam int PATTERN_SLOTS   = 16;
  localparam int LENGTH_BITS     = 5;
  localparam int COUNT_BITS      = 16;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = PATTERN_REG_BITS;

  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET      = 5'd1;
  localparam logic [COUNT_BITS-1:0]  MAX_MATCHES_RESET = 16'd1024;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_MAX_MATCHES    = 2'd3
  } cfg_idx_t;

endpackage

/* hw/rtl/byte_pattern_scanner.sv */
`timescale 1ns / 1ps
// A match or summary result is registered and appears on the output in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the only back-pressure comes from a stalled,
// occupied output register.
// Reset (synchronous, rst_n low): configuration returns to its reset values, the window
// fill count and the match count clear, and the output register empties.

module byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int ADDRESS_BITS      = 48
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  cfg_wr_en,
  input  logic [bps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [bps_pkg::CFG_DATA_BITS-1:0]     cfg_wr_data,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bps_pkg::DATA_BITS-1:0]         in_data_byte,
  input  logic [ADDRESS_BITS-1:0]               in_byte_address,
  input  logic                                  in_region_start,
  input  logic                                  in_end_of_scan,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ADDRESS_BITS-1:0]               out_match_address,
  output logic [bps_pkg::COUNT_BITS-1:0]        out_match_number,
  output logic                                  out_is_summary,
  output logic [bps_pkg::COUNT_BITS-1:0]        out_total_matches
);

  localparam int LW     = bps_pkg::LENGTH_BITS;
  localparam int CW     = bps_pkg::COUNT_BITS;
  localparam int DW     = bps_pkg::DATA_BITS;
  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

  localparam logic [LW-1:0]     MAX_LEN  = LW'(MAX_PATTERN_BYTES);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN_BYTES);

  // Configuration registers
  logic [bps_pkg::PATTERN_REG_BITS-1:0] pat_low_r;
  logic [bps_pkg::PATTERN_REG_BITS-1:0] pat_high_r;
  logic [LW-1:0]                        pat_len_r;
  logic [CW-1:0]                        max_matches_r;

  // Scan state
  logic [DW-1:0]     window_r   [MAX_PATTERN_BYTES];
  logic [DW-1:0]     window_nxt [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [ADDRESS_BITS-1:0] out_addr_r, out_addr_nxt;
  logic [CW-1:0]           out_num_r, out_num_nxt;
  logic                    out_sum_r, out_sum_nxt;
  logic [CW-1:0]           out_total_r, out_total_nxt;

  logic                    in_accept;
  logic                    out_free;
  logic [LW-1:0]           len_eff;
  logic [2*bps_pkg::PATTERN_REG_BITS-1:0] pat_all;
  logic [DW-1:0]           pat_byte [bps_pkg::PATTERN_SLOTS];
  logic [LW-1:0]           pat_sel  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                    hit;
  logic                    report;
  logic [CW-1:0]           total;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !out_free;
  assign in_accept = in_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r     <= '0;
      pat_high_r    <= '0;
      pat_len_r     <= bps_pkg::LENGTH_RESET;
      max_matches_r <= bps_pkg::MAX_MATCHES_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bps_pkg::CFG_PATTERN_LOW:    pat_low_r     <= cfg_wr_data;
        bps_pkg::CFG_PATTERN_HIGH:   pat_high_r    <= cfg_wr_data;
        bps_pkg::CFG_PATTERN_LENGTH: pat_len_r     <= cfg_wr_data[LW-1:0];
        bps_pkg::CFG_MAX_MATCHES:    max_matches_r <= cfg_wr_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_high_r, pat_low_r};

  always_comb begin
    for (int i = 0; i < bps_pkg::PATTERN_SLOTS; i++) begin
      pat_byte[i] = pat_all[i*DW +: DW];
    end
  end

  // Lengths above the window depth compare the whole window.
  assign len_eff = (pat_len_r > MAX_LEN) ? MAX_LEN : pat_len_r;

  always_comb begin
    window_nxt[0] = in_data_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      window_nxt[j] = window_r[j-1];
    end
    if (in_region_start) begin
      fill_nxt = FILL_W'(1);
    end else if (fill_r == FILL_MAX) begin
      fill_nxt = FILL_MAX;
    end else begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  // Window entry j holds the byte that lines up with pattern byte len - 1 - j.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      pat_sel[j] = len_eff - LW'(j) - LW'(1);
      byte_ok[j] = (LW'(j) >= len_eff) ||
                   (window_nxt[j] == pat_byte[pat_sel[j][LW-2:0]]);
    end
  end

  assign hit    = (len_eff != '0) && (LW'(fill_nxt) >= len_eff) && (&byte_ok);
  assign report = hit && (count_r < max_matches_r);
  assign total  = (count_r < max_matches_r) ? count_r : max_matches_r;

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_num_nxt   = out_num_r;
    out_sum_nxt   = out_sum_r;
    out_total_nxt = out_total_r;
    if (in_accept) begin
      if (in_end_of_scan) begin
        count_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_addr_nxt  = '0;
        out_num_nxt   = '0;
        out_sum_nxt   = 1'b1;
        out_total_nxt = total;
      end else if (report) begin
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_addr_nxt  = in_byte_address - ADDRESS_BITS'(len_eff - LW'(1));
        out_num_nxt   = count_r;
        out_sum_nxt   = 1'b0;
        out_total_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        fill_r <= in_end_of_scan ? '0 : fill_nxt;
      end
    end
  end

  // Window bytes beyond the fill count are never compared, so they need no clearing.
  always_ff @(posedge clk) begin
    if (in_accept && !in_end_of_scan) begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
        window_r[j] <= window_nxt[j];
      end
    end
    out_addr_r  <= out_addr_nxt;
    out_num_r   <= out_num_nxt;
    out_sum_r   <= out_sum_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_match_address = out_addr_r;
  assign out_match_number  = out_num_r;
  assign out_is_summary    = out_sum_r;
  assign out_total_matches = out_total_r;

endmodule

/* hw/rtl/bps_checker.sv */
`timescale 1ns / 1ps

module bps_checker #(
  parameter int ADDRESS_BITS = 48
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_end_of_scan,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [ADDRESS_BITS-1:0]            out_match_address,
  input logic [bps_pkg::COUNT_BITS-1:0]     out_match_number,
  input logic                               out_is_summary,
  input logic [bps_pkg::COUNT_BITS-1:0]     out_total_matches
);

  // A held result beat keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_address) &&
      $stable(out_match_number) && $stable(out_is_summary) && $stable(out_total_matches))
    else $error("result beat changed while stalled");

  // The input side is only held back by a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // No result appears without an accepted input beat.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall) && !(out_valid && out_stall) |=> !out_valid)
    else $error("result beat without an input beat");

  // An end-of-scan beat always yields a summary next cycle.
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_scan |=> out_valid && out_is_summary)
    else $error("end of scan gave no summary");

  // Summary and match results keep the unused fields at zero.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_summary && out_match_address == '0 && out_match_number == '0) ||
      (!out_is_summary && out_total_matches == '0))
    else $error("unused result field not zero");

endmodule

bind byte_pattern_scanner bps_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_bps_checker (.*);
